// ----- hdl/erm_pkg.sv -----
// Package for the Euler angle to rotation matrix core.
// Holds the fixed-point constants, the arctangent table, the lane types and the rounding helpers.
// Depends on nothing; erm_prep, erm_cordic_cell, erm_matrix and the top level import it.
`default_nettype none

package erm_pkg;

  localparam int unsigned AtanEntries = 24;

  localparam logic signed [33:0] Q28Pi     = 34'sd843314857;
  localparam logic signed [33:0] Q28HalfPi = 34'sd421657428;
  localparam logic signed [33:0] Q28TwoPi  = 34'sd1686629713;
  localparam logic signed [31:0] Q28Gain   = 32'sd163008218;
  localparam logic signed [15:0] Q14One    = 16'sd16384;
  localparam logic signed [32:0] Q28Half   = 33'sd8192;
  localparam logic signed [47:0] Q42Half   = 48'sd134217728;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } erm_lane_t;

  typedef struct packed {
    erm_lane_t [2:0] lane;
    logic      [2:0] flip;
  } erm_rot_t;

  function automatic logic signed [31:0] atan_q28(input int unsigned idx);
    logic signed [31:0] a;
    unique case (idx)
      0:       a = 32'sd210828714;
      1:       a = 32'sd124459457;
      2:       a = 32'sd65760959;
      3:       a = 32'sd33381290;
      4:       a = 32'sd16755422;
      5:       a = 32'sd8385879;
      6:       a = 32'sd4193963;
      7:       a = 32'sd2097109;
      8:       a = 32'sd1048571;
      9:       a = 32'sd524287;
      10:      a = 32'sd262144;
      11:      a = 32'sd131072;
      12:      a = 32'sd65536;
      13:      a = 32'sd32768;
      14:      a = 32'sd16384;
      15:      a = 32'sd8192;
      16:      a = 32'sd4096;
      17:      a = 32'sd2048;
      18:      a = 32'sd1024;
      19:      a = 32'sd512;
      20:      a = 32'sd256;
      21:      a = 32'sd128;
      22:      a = 32'sd64;
      23:      a = 32'sd32;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  function automatic q14_t sat_q14(input logic signed [47:0] v);
    q14_t r;
    if (v > 48'sd16384) begin
      r = Q14One;
    end else if (v < -48'sd16384) begin
      r = -Q14One;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic q14_t round_q28(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = v + Q28Half;
    return sat_q14(48'(t >>> 14));
  endfunction

endpackage

`default_nettype wire

// ----- hdl/erm_in_if.sv -----
// Input channel of the rotation matrix core: one item is a triple of Q4.12 angles.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface erm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
  modport sink   (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/erm_out_if.sv -----
// Output channel of the rotation matrix core: one item is nine Q2.14 matrix elements.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface erm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10, output m11,
                  output m12, output m20, output m21, output m22, input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10, input m11,
                  input m12, input m20, input m21, input m22, output ready);
endinterface

`default_nettype wire

// ----- hdl/erm_prep.sv -----
// Angle range reduction ahead of the CORDIC row: two pipeline stages.
// Widens Q4.12 angles to Q28, folds them into [-pi/2, pi/2] and seeds x, y. Uses erm_pkg.
`default_nettype none

module erm_prep import erm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [2:0][15:0] angle_i,
  output logic            valid_o,
  input  logic            ready_i,
  output erm_rot_t        data_o
);

  logic                     v1_q, v2_q;
  logic                     rdy1, rdy2;
  logic signed [2:0][31:0]  z1_d, z1_q;
  erm_rot_t                 rot_d, rot_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign data_o  = rot_q;

  always_comb begin
    logic signed [33:0] za;
    za = '0;
    for (int i = 0; i < 3; i++) begin
      za = 34'(signed'(angle_i[i])) <<< 16;
      if (za > Q28Pi) begin
        za = za - Q28TwoPi;
      end else if (za < -Q28Pi) begin
        za = za + Q28TwoPi;
      end
      z1_d[i] = 32'(za);
    end
  end

  always_comb begin
    logic signed [33:0] zb;
    zb    = '0;
    rot_d = '0;
    for (int i = 0; i < 3; i++) begin
      zb = 34'(signed'(z1_q[i]));
      rot_d.flip[i] = 1'b0;
      if (zb > Q28HalfPi) begin
        zb = zb - Q28Pi;
        rot_d.flip[i] = 1'b1;
      end else if (zb < -Q28HalfPi) begin
        zb = zb + Q28Pi;
        rot_d.flip[i] = 1'b1;
      end
      rot_d.lane[i].x = Q28Gain;
      rot_d.lane[i].y = 32'sd0;
      rot_d.lane[i].z = 32'(zb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) z1_q <= z1_d;
    if (rdy2) rot_q <= rot_d;
  end

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (34'(rot_q.lane[0].z) <= Q28HalfPi) && (34'(rot_q.lane[0].z) >= -Q28HalfPi)
      && (34'(rot_q.lane[2].z) <= Q28HalfPi) && (34'(rot_q.lane[2].z) >= -Q28HalfPi))
    else $error("folded angle outside half pi");

endmodule

`default_nettype wire

// ----- hdl/erm_cordic_cell.sv -----
// One CORDIC rotation step for the three angle lanes, with its own pipeline register.
// Cells are chained in a row; STAGE sets the shift and the arctangent. Uses erm_pkg.
`default_nettype none

module erm_cordic_cell import erm_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  erm_rot_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output erm_rot_t data_o
);

  localparam logic signed [31:0] Atan = atan_q28(STAGE);

  logic     valid_q;
  erm_rot_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic signed [31:0] xs, ys, zs;
    xs     = '0;
    ys     = '0;
    zs     = '0;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      xs = data_i.lane[i].x;
      ys = data_i.lane[i].y;
      zs = data_i.lane[i].z;
      if (!zs[31]) begin
        data_d.lane[i].x = xs - (ys >>> STAGE);
        data_d.lane[i].y = ys + (xs >>> STAGE);
        data_d.lane[i].z = zs - Atan;
      end else begin
        data_d.lane[i].x = xs + (ys >>> STAGE);
        data_d.lane[i].y = ys - (xs >>> STAGE);
        data_d.lane[i].z = zs + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) data_q <= data_d;
  end

endmodule

`default_nettype wire

// ----- hdl/erm_matrix.sv -----
// Rounds the CORDIC outputs to Q2.14 sine/cosine and forms the nine matrix elements.
// Five pipeline stages: round, pair products, triple products, sums, final round. Uses erm_pkg.
`default_nettype none

module erm_matrix import erm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  erm_rot_t       data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output q14_t     [8:0] m_o
);

  localparam int unsigned Stages = 5;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  // stage 0
  q14_t [2:0] s_d, c_d, s_q, c_q;
  // stage 1
  logic signed [31:0] czcy_q, szcy_q, cysx_q, cycx_q, czsy_q, szsy_q;
  logic signed [31:0] szcx_q, szsx_q, czcx_q, czsx_q;
  q14_t               sx1_q, cx1_q, sy1_q;
  // stage 2
  logic signed [47:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [31:0] szcx2_q, szsx2_q, czcx2_q, czsx2_q;
  q14_t               m00_2_q, m10_2_q, m20_2_q, m21_2_q, m22_2_q;
  // stage 3
  logic signed [47:0] a01_q, a02_q, a11_q, a12_q;
  q14_t               m00_3_q, m10_3_q, m20_3_q, m21_3_q, m22_3_q;
  // stage 4
  q14_t [8:0] m_q;

  assign rdy[Stages] = ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[Stages-1];
  assign m_o     = m_q;

  always_comb begin
    logic signed [32:0] xf, yf;
    xf = '0;
    yf = '0;
    for (int i = 0; i < 3; i++) begin
      xf = 33'(data_i.lane[i].x);
      yf = 33'(data_i.lane[i].y);
      if (data_i.flip[i]) begin
        xf = -xf;
        yf = -yf;
      end
      c_d[i] = round_q28(xf);
      s_d[i] = round_q28(yf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s_q <= s_d;
      c_q <= c_d;
    end
    if (rdy[1]) begin
      czcy_q <= 32'(c_q[2] * c_q[1]);
      szcy_q <= 32'(s_q[2] * c_q[1]);
      cysx_q <= 32'(c_q[1] * s_q[0]);
      cycx_q <= 32'(c_q[1] * c_q[0]);
      czsy_q <= 32'(c_q[2] * s_q[1]);
      szsy_q <= 32'(s_q[2] * s_q[1]);
      szcx_q <= 32'(s_q[2] * c_q[0]);
      szsx_q <= 32'(s_q[2] * s_q[0]);
      czcx_q <= 32'(c_q[2] * c_q[0]);
      czsx_q <= 32'(c_q[2] * s_q[0]);
      sx1_q  <= s_q[0];
      cx1_q  <= c_q[0];
      sy1_q  <= s_q[1];
    end
    if (rdy[2]) begin
      t01_q   <= 48'(czsy_q) * 48'(sx1_q);
      t02_q   <= 48'(czsy_q) * 48'(cx1_q);
      t11_q   <= 48'(szsy_q) * 48'(sx1_q);
      t12_q   <= 48'(szsy_q) * 48'(cx1_q);
      szcx2_q <= szcx_q;
      szsx2_q <= szsx_q;
      czcx2_q <= czcx_q;
      czsx2_q <= czsx_q;
      m00_2_q <= round_q28(33'(czcy_q));
      m10_2_q <= round_q28(33'(szcy_q));
      m21_2_q <= round_q28(33'(cysx_q));
      m22_2_q <= round_q28(33'(cycx_q));
      m20_2_q <= sat_q14(-48'(sy1_q));
    end
    if (rdy[3]) begin
      a01_q   <= t01_q - (48'(szcx2_q) <<< 14) + Q42Half;
      a02_q   <= t02_q + (48'(szsx2_q) <<< 14) + Q42Half;
      a11_q   <= t11_q + (48'(czcx2_q) <<< 14) + Q42Half;
      a12_q   <= t12_q - (48'(czsx2_q) <<< 14) + Q42Half;
      m00_3_q <= m00_2_q;
      m10_3_q <= m10_2_q;
      m20_3_q <= m20_2_q;
      m21_3_q <= m21_2_q;
      m22_3_q <= m22_2_q;
    end
    if (rdy[4]) begin
      m_q[0] <= m00_3_q;
      m_q[1] <= sat_q14(a01_q >>> 28);
      m_q[2] <= sat_q14(a02_q >>> 28);
      m_q[3] <= m10_3_q;
      m_q[4] <= sat_q14(a11_q >>> 28);
      m_q[5] <= sat_q14(a12_q >>> 28);
      m_q[6] <= m20_3_q;
      m_q[7] <= m21_3_q;
      m_q[8] <= m22_3_q;
    end
  end

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (c_q[0] <= Q14One) && (c_q[0] >= -Q14One) && (s_q[1] <= Q14One)
      && (s_q[1] >= -Q14One))
    else $error("sine or cosine past one");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (m_q[1] <= Q14One) && (m_q[1] >= -Q14One) && (m_q[4] <= Q14One)
      && (m_q[4] >= -Q14One))
    else $error("summed element not saturated");

  a_m20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (m_q[6] <= Q14One) && (m_q[6] >= -Q14One))
    else $error("m20 out of range");

endmodule

`default_nettype wire

// ----- hdl/euler_to_rotation_matrix_core.sv -----
// Top level of the Z-Y-X Euler angle to rotation matrix core.
// Chains erm_prep, a row of erm_cordic_cell and erm_matrix; uses erm_pkg, erm_in_if, erm_out_if.
//
//   channel  dir  item                          handshake
//   in_i     in   angle_x/y/z, Q4.12 radians    valid/ready
//   out_o    out  m00..m22, Q2.14               valid/ready
//
// One item per cycle sustained while out_o.ready stays high; items pass the fold stages of
// erm_prep, the register of each CORDIC cell and the product pipeline of erm_matrix, in order.
// Every stage has its own valid bit and takes a new item when it is empty or its successor
// moves, so bubbles close up and input is taken while a finished result waits at out_o.
// Reset clears all valid bits; the datapath is not reset.
`default_nettype none

module euler_to_rotation_matrix_core import erm_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  erm_in_if.sink    in_i,
  erm_out_if.source out_o
);

  logic [CORDIC_STAGES:0] cv;
  logic [CORDIC_STAGES:0] cr;
  erm_rot_t               cd [CORDIC_STAGES+1];
  q14_t [8:0]             m;

  erm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .angle_i ({in_i.angle_z, in_i.angle_y, in_i.angle_x}),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .data_o  (cd[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    erm_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (cr[k]),
      .data_i  (cd[k]),
      .valid_o (cv[k+1]),
      .ready_i (cr[k+1]),
      .data_o  (cd[k+1])
    );
  end

  erm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[CORDIC_STAGES]),
    .ready_o (cr[CORDIC_STAGES]),
    .data_i  (cd[CORDIC_STAGES]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .m_o     (m)
  );

  assign out_o.m00 = m[0];
  assign out_o.m01 = m[1];
  assign out_o.m02 = m[2];
  assign out_o.m10 = m[3];
  assign out_o.m11 = m[4];
  assign out_o.m12 = m[5];
  assign out_o.m20 = m[6];
  assign out_o.m21 = m[7];
  assign out_o.m22 = m[8];

endmodule

`default_nettype wire
